@@ src/crcm_pkg.sv @@
// Shared types, widths and codes of the character range class map.
package crcm_pkg;

  localparam int MAX_RANGES = 64;
  localparam int IDX_W      = $clog2(MAX_RANGES);
  localparam int CNT_W      = $clog2(MAX_RANGES + 1);
  localparam int WCNT_W     = $clog2(MAX_RANGES + 3);
  localparam int CP_W       = 21;
  localparam int CP1_W      = CP_W + 1;
  localparam int CLS_W      = 8;
  localparam int ENT_W      = 2 * CP_W + CLS_W;
  localparam int RAM_DEPTH  = 2 << IDX_W;
  localparam int RAM_AW     = IDX_W + 1;

  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;
  localparam logic ST_DONE     = 1'b0;
  localparam logic ST_FULL     = 1'b1;

  typedef struct packed {
    logic [CP_W-1:0]  first;
    logic [CP_W-1:0]  last;
    logic [CLS_W-1:0] cls;
  } entry_t;

  typedef struct packed {
    logic             mode;
    logic [CP_W-1:0]  range_first;
    logic [CP_W-1:0]  range_last;
    logic [CLS_W-1:0] class_id;
    logic [CP_W-1:0]  code_point;
  } item_t;

  typedef struct packed {
    logic [CLS_W-1:0] class_out;
    logic             matched;
    logic             status;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [RAM_AW-1:0] waddr;
    logic [ENT_W-1:0]  wdata;
    logic [RAM_AW-1:0] raddr;
  } ram_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LK_RD,
    S_LK_EV,
    S_AD_RD,
    S_AD_EV,
    S_EMIT,
    S_CP_RD,
    S_CP_WR,
    S_AD_END,
    S_FIN,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    AFT_SCAN,
    AFT_COPY,
    AFT_FIN
  } after_e;

endpackage

@@ src/crcm_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module crcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/crcm_seq.sv @@
// Sequencer: binary search for lookups and streaming table rebuild for adds.
module crcm_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  crcm_pkg::item_t            item_i,
  input  logic [crcm_pkg::CLS_W-1:0] default_class_i,
  input  logic                       slot_free_i,
  output logic                       idle_o,
  output logic                       res_valid_o,
  output crcm_pkg::res_t             res_o,
  output crcm_pkg::ram_req_t         ram_o,
  input  logic [crcm_pkg::ENT_W-1:0] ram_rdata_i
);

  crcm_pkg::state_e state_q, state_d;
  crcm_pkg::after_e after_q, after_d;
  logic [crcm_pkg::CP_W-1:0]   f_q, f_d;
  logic [crcm_pkg::CP_W-1:0]   l_q, l_d;
  logic [crcm_pkg::CLS_W-1:0]  c_q, c_d;
  logic [crcm_pkg::CNT_W-1:0]  idx_q, idx_d;
  logic [crcm_pkg::CNT_W-1:0]  hi_q, hi_d;
  logic [crcm_pkg::CNT_W-1:0]  mid_q, mid_d;
  logic [crcm_pkg::CNT_W-1:0]  count_q, count_d;
  logic [crcm_pkg::WCNT_W-1:0] wcnt_q, wcnt_d;
  logic                        bank_q, bank_d;
  crcm_pkg::entry_t            pend_q [3];
  crcm_pkg::entry_t            pend_d [3];
  logic [1:0]                  pn_q, pn_d;
  logic [1:0]                  pi_q, pi_d;
  crcm_pkg::res_t              res_q, res_d;

  crcm_pkg::entry_t            e;
  crcm_pkg::entry_t            new_ent;
  logic [crcm_pkg::CNT_W-1:0]  mid;
  logic [crcm_pkg::CNT_W-1:0]  rd_idx;
  logic [crcm_pkg::WCNT_W-1:0] widx;
  logic                        below, above;

  assign e       = crcm_pkg::entry_t'(ram_rdata_i);
  assign new_ent = '{first: f_q, last: l_q, cls: c_q};
  assign mid     = idx_q + ((hi_q - idx_q) >> 1);
  // Stored range lies wholly below, or wholly above, the range being added.
  assign below = ({1'b0, f_q} > ({1'b0, e.last} + crcm_pkg::CP1_W'(1)))
              || ((f_q > e.last) && (c_q != e.cls));
  assign above = ({1'b0, e.first} > ({1'b0, l_q} + crcm_pkg::CP1_W'(1)))
              || ((e.first > l_q) && (c_q != e.cls));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= crcm_pkg::S_IDLE;
      count_q <= '0;
      bank_q  <= 1'b0;
      pi_q    <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      bank_q  <= bank_d;
      pi_q    <= pi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    after_q <= after_d;
    f_q     <= f_d;
    l_q     <= l_d;
    c_q     <= c_d;
    idx_q   <= idx_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    wcnt_q  <= wcnt_d;
    pend_q  <= pend_d;
    pn_q    <= pn_d;
    res_q   <= res_d;
  end

  always_comb begin
    state_d = state_q;
    after_d = after_q;
    f_d     = f_q;
    l_d     = l_q;
    c_d     = c_q;
    idx_d   = idx_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    count_d = count_q;
    wcnt_d  = wcnt_q;
    bank_d  = bank_q;
    pend_d  = pend_q;
    pn_d    = pn_q;
    pi_d    = pi_q;
    res_d   = res_q;
    rd_idx  = idx_q;
    widx    = wcnt_q;
    ram_o.we    = 1'b0;
    ram_o.wdata = pend_q[pi_q];
    unique case (state_q)
      crcm_pkg::S_IDLE: begin
        if (start_i) begin
          idx_d  = '0;
          hi_d   = count_q;
          wcnt_d = '0;
          l_d    = item_i.range_last;
          c_d    = item_i.class_id;
          if (item_i.mode == crcm_pkg::MODE_LOOKUP) begin
            // The search key rides in the first-code-point register.
            f_d     = item_i.code_point;
            state_d = crcm_pkg::S_LK_RD;
          end else if (item_i.range_first > item_i.range_last) begin
            res_d   = '{class_out: '0, matched: 1'b0, status: crcm_pkg::ST_DONE};
            state_d = crcm_pkg::S_OUT;
          end else begin
            f_d     = item_i.range_first;
            state_d = crcm_pkg::S_AD_RD;
          end
        end
      end
      crcm_pkg::S_LK_RD: begin
        rd_idx = mid;
        mid_d  = mid;
        if (idx_q < hi_q) begin
          state_d = crcm_pkg::S_LK_EV;
        end else begin
          res_d   = '{class_out: default_class_i, matched: 1'b0,
                      status: crcm_pkg::ST_DONE};
          state_d = crcm_pkg::S_OUT;
        end
      end
      crcm_pkg::S_LK_EV: begin
        if (f_q > e.last) begin
          idx_d   = mid_q + crcm_pkg::CNT_W'(1);
          state_d = crcm_pkg::S_LK_RD;
        end else if (f_q < e.first) begin
          hi_d    = mid_q;
          state_d = crcm_pkg::S_LK_RD;
        end else begin
          res_d   = '{class_out: e.cls, matched: 1'b1, status: crcm_pkg::ST_DONE};
          state_d = crcm_pkg::S_OUT;
        end
      end
      crcm_pkg::S_AD_RD: begin
        if (idx_q == count_q) begin
          state_d = crcm_pkg::S_AD_END;
        end else begin
          state_d = crcm_pkg::S_AD_EV;
        end
      end
      crcm_pkg::S_AD_EV: begin
        idx_d   = idx_q + crcm_pkg::CNT_W'(1);
        pn_d    = 2'd0;
        after_d = crcm_pkg::AFT_SCAN;
        pend_d[0] = e;
        priority if (below) begin
          pn_d = 2'd1;
        end else if (above) begin
          pend_d[0] = new_ent;
          pend_d[1] = e;
          pn_d      = 2'd2;
          after_d   = crcm_pkg::AFT_COPY;
        end else if (e.cls == c_q) begin
          if (e.first <= f_q) begin
            f_d = e.first;
          end else if (e.last > l_q) begin
            pend_d[0] = '{first: f_q, last: e.last, cls: c_q};
            pn_d      = 2'd1;
            after_d   = crcm_pkg::AFT_COPY;
          end
        end else if (e.first < f_q) begin
          pend_d[0] = '{first: e.first, last: f_q - crcm_pkg::CP_W'(1), cls: e.cls};
          pn_d      = 2'd1;
          if (e.last > l_q) begin
            pend_d[1] = new_ent;
            pend_d[2] = '{first: l_q + crcm_pkg::CP_W'(1), last: e.last, cls: e.cls};
            pn_d      = 2'd3;
            after_d   = crcm_pkg::AFT_COPY;
          end
        end else if (e.last > l_q) begin
          pend_d[0] = new_ent;
          pend_d[1] = '{first: l_q + crcm_pkg::CP_W'(1), last: e.last, cls: e.cls};
          pn_d      = 2'd2;
          after_d   = crcm_pkg::AFT_COPY;
        end
        // A same-class range that already covers the new one ends the add.
        if (!below && !above && (e.cls == c_q) && (e.first <= f_q) && (e.last >= l_q)) begin
          res_d   = '{class_out: '0, matched: 1'b0, status: crcm_pkg::ST_DONE};
          state_d = crcm_pkg::S_OUT;
        end else if (pn_d != 2'd0) begin
          state_d = crcm_pkg::S_EMIT;
        end else begin
          state_d = crcm_pkg::S_AD_RD;
        end
      end
      crcm_pkg::S_EMIT: begin
        ram_o.we = (wcnt_q < crcm_pkg::WCNT_W'(crcm_pkg::MAX_RANGES));
        wcnt_d   = wcnt_q + crcm_pkg::WCNT_W'(1);
        if (pi_q == pn_q - 2'd1) begin
          pi_d = '0;
          unique case (after_q)
            crcm_pkg::AFT_SCAN: state_d = crcm_pkg::S_AD_RD;
            crcm_pkg::AFT_COPY: state_d = crcm_pkg::S_CP_RD;
            crcm_pkg::AFT_FIN:  state_d = crcm_pkg::S_FIN;
            default:            state_d = crcm_pkg::S_FIN;
          endcase
        end else begin
          pi_d = pi_q + 2'd1;
        end
      end
      crcm_pkg::S_CP_RD: begin
        if (idx_q == count_q) begin
          state_d = crcm_pkg::S_FIN;
        end else begin
          state_d = crcm_pkg::S_CP_WR;
        end
      end
      crcm_pkg::S_CP_WR: begin
        ram_o.wdata = ram_rdata_i;
        ram_o.we    = (wcnt_q < crcm_pkg::WCNT_W'(crcm_pkg::MAX_RANGES));
        wcnt_d      = wcnt_q + crcm_pkg::WCNT_W'(1);
        idx_d       = idx_q + crcm_pkg::CNT_W'(1);
        state_d     = crcm_pkg::S_CP_RD;
      end
      crcm_pkg::S_AD_END: begin
        pend_d[0] = new_ent;
        pn_d      = 2'd1;
        after_d   = crcm_pkg::AFT_FIN;
        state_d   = crcm_pkg::S_EMIT;
      end
      crcm_pkg::S_FIN: begin
        if (wcnt_q > crcm_pkg::WCNT_W'(crcm_pkg::MAX_RANGES)) begin
          res_d = '{class_out: '0, matched: 1'b0, status: crcm_pkg::ST_FULL};
        end else begin
          bank_d  = ~bank_q;
          count_d = wcnt_q[crcm_pkg::CNT_W-1:0];
          res_d   = '{class_out: '0, matched: 1'b0, status: crcm_pkg::ST_DONE};
        end
        state_d = crcm_pkg::S_OUT;
      end
      crcm_pkg::S_OUT: begin
        if (slot_free_i) begin
          state_d = crcm_pkg::S_IDLE;
        end
      end
      default: state_d = crcm_pkg::S_IDLE;
    endcase
    ram_o.raddr = {bank_q, rd_idx[crcm_pkg::IDX_W-1:0]};
    ram_o.waddr = {~bank_q, widx[crcm_pkg::IDX_W-1:0]};
  end

  assign idle_o      = (state_q == crcm_pkg::S_IDLE);
  assign res_valid_o = (state_q == crcm_pkg::S_OUT);
  assign res_o       = res_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= crcm_pkg::CNT_W'(crcm_pkg::MAX_RANGES))
    else $error("entry count beyond table depth");
  a_search_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == crcm_pkg::S_LK_EV) |-> (idx_q <= hi_q) && (hi_q <= count_q))
    else $error("search window out of order");
  a_bank_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bank_q != $past(bank_q)) |-> ($past(state_q) == crcm_pkg::S_FIN))
    else $error("bank swap outside commit");
  a_scan_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == crcm_pkg::S_AD_RD || state_q == crcm_pkg::S_CP_RD) |-> idx_q <= count_q)
    else $error("scan index beyond entry count");
`endif

endmodule

@@ src/char_range_class_map.sv @@
// Character range class map: sorted range table with class lookup and range insertion.
//
// The block keeps up to MAX_RANGES disjoint, ascending code-point ranges, each
// tagged with an 8-bit class, in a RAM of two banks. A lookup transfer runs a
// binary search over the active bank. Each search step reads one entry and
// compares it in the next cycle, because the RAM read port is registered. An
// add transfer streams the active bank into the other bank while cutting,
// splitting and merging ranges, and swaps banks at the end. An add that would
// exceed the table depth answers status 1 and leaves the old bank active. An
// empty range answers status 0 at once. A range already covered by the same
// class answers status 0 as soon as the scan reaches the covering range, and
// the table stays as it was. One item is in work at a time; a new item is
// taken while the previous result still waits in the output register. The
// configuration channel is always ready and writes default_class, returned on
// a lookup miss.
module char_range_class_map (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       mode_i,
  input  logic [crcm_pkg::CP_W-1:0]  range_first_i,
  input  logic [crcm_pkg::CP_W-1:0]  range_last_i,
  input  logic [crcm_pkg::CLS_W-1:0] class_id_i,
  input  logic [crcm_pkg::CP_W-1:0]  code_point_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [crcm_pkg::CLS_W-1:0] class_out_o,
  output logic                       matched_o,
  output logic                       status_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [crcm_pkg::CLS_W-1:0] cfg_data_i
);

  logic [crcm_pkg::CLS_W-1:0] default_class_q;
  logic                       out_valid_q;
  crcm_pkg::res_t             out_q;
  crcm_pkg::item_t            item;
  crcm_pkg::res_t             res;
  crcm_pkg::ram_req_t         ram_req;
  logic [crcm_pkg::ENT_W-1:0] ram_rdata;
  logic                       idle;
  logic                       res_valid;
  logic                       slot_free;

  // The configuration register is written in any cycle; the user only does so while idle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_class_q <= '0;
    end else if (cfg_valid_i) begin
      default_class_q <= cfg_data_i;
    end
  end

  assign item = '{mode: mode_i, range_first: range_first_i, range_last: range_last_i,
                  class_id: class_id_i, code_point: code_point_i};

  // Input transfers are taken only while the sequencer has no item in work.
  assign in_stall_o = !idle;

  // The output register is free when empty or when its result leaves this cycle.
  assign slot_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign class_out_o = out_q.class_out;
  assign matched_o   = out_q.matched;
  assign status_o    = out_q.status;

  crcm_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (in_valid_i && idle),
    .item_i         (item),
    .default_class_i(default_class_q),
    .slot_free_i    (slot_free),
    .idle_o         (idle),
    .res_valid_o    (res_valid),
    .res_o          (res),
    .ram_o          (ram_req),
    .ram_rdata_i    (ram_rdata)
  );

  crcm_ram #(
    .WIDTH(crcm_pkg::ENT_W),
    .DEPTH(crcm_pkg::RAM_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_req.we),
    .waddr_i(ram_req.waddr),
    .wdata_i(ram_req.wdata),
    .raddr_i(ram_req.raddr),
    .rdata_o(ram_rdata)
  );

endmodule

@@ bench/range_map_checker.sv @@
// Checker for the character range class map: predicts each result and compares it.
`timescale 1ns / 1ps
module range_map_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic                       mode_i,
  input  logic [crcm_pkg::CP_W-1:0]  range_first_i,
  input  logic [crcm_pkg::CP_W-1:0]  range_last_i,
  input  logic [crcm_pkg::CLS_W-1:0] class_id_i,
  input  logic [crcm_pkg::CP_W-1:0]  code_point_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [crcm_pkg::CLS_W-1:0] class_out_i,
  input  logic                       matched_i,
  input  logic                       status_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [crcm_pkg::CLS_W-1:0] cfg_data_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  localparam int WORK_MAX = crcm_pkg::MAX_RANGES + 2;

  // Committed table and default class of the prediction.
  crcm_pkg::entry_t           map_tab[crcm_pkg::MAX_RANGES];
  int                         map_size;
  logic [crcm_pkg::CLS_W-1:0] miss_class;
  crcm_pkg::res_t             expected_res[$];

  // Scratch table used while an add is worked out.
  crcm_pkg::entry_t wk[WORK_MAX];
  int               wk_n;

  function automatic void wk_delete(int p);
    if (p >= wk_n) return;
    for (int i = p; i < wk_n - 1; i++) wk[i] = wk[i+1];
    wk_n--;
  endfunction

  function automatic void wk_insert(int p, logic [crcm_pkg::CP_W-1:0] f,
                                    logic [crcm_pkg::CP_W-1:0] l,
                                    logic [crcm_pkg::CLS_W-1:0] c);
    if (wk_n >= WORK_MAX || p > wk_n) return;
    for (int i = wk_n; i > p; i--) wk[i] = wk[i-1];
    wk[p] = '{first: f, last: l, cls: c};
    wk_n++;
  endfunction

  // Insert a range; returns the status of the add.
  function automatic logic insert_range(logic [crcm_pkg::CP_W-1:0] f_in,
                                        logic [crcm_pkg::CP_W-1:0] l,
                                        logic [crcm_pkg::CLS_W-1:0] c);
    int p;
    bit put_new;
    logic [31:0] f, ef, el, lw;
    logic [crcm_pkg::CLS_W-1:0] ec;
    p = 0;
    put_new = 1;
    f = f_in;
    lw = l;
    if (f > lw) return crcm_pkg::ST_DONE;
    wk_n = map_size;
    for (int i = 0; i < map_size; i++) wk[i] = map_tab[i];
    while (p < wk_n) begin
      ef = wk[p].first;
      el = wk[p].last;
      ec = wk[p].cls;
      if (f > el + 1 || (f > el && c != ec)) begin
        p++;
      end else if (ef > lw + 1 || (ef > lw && c != ec)) begin
        break;
      end else if (ec == c) begin
        if (ef <= f) begin
          if (el >= lw) return crcm_pkg::ST_DONE;
          f = ef;
          wk_delete(p);
        end else if (el <= lw) begin
          wk_delete(p);
        end else begin
          wk[p].first = f[crcm_pkg::CP_W-1:0];
          put_new = 0;
          break;
        end
      end else if (ef < f) begin
        wk[p].last = f[crcm_pkg::CP_W-1:0] - 1'b1;
        if (el <= lw) begin
          p++;
        end else begin
          wk_insert(p + 1, f[crcm_pkg::CP_W-1:0], l, c);
          wk_insert(p + 2, l + 1'b1, el[crcm_pkg::CP_W-1:0], ec);
          put_new = 0;
          break;
        end
      end else if (el <= lw) begin
        wk_delete(p);
      end else begin
        wk[p].first = l + 1'b1;
        break;
      end
    end
    if (put_new) wk_insert(p, f[crcm_pkg::CP_W-1:0], l, c);
    if (wk_n > crcm_pkg::MAX_RANGES) return crcm_pkg::ST_FULL;
    map_size = wk_n;
    for (int i = 0; i < wk_n; i++) map_tab[i] = wk[i];
    return crcm_pkg::ST_DONE;
  endfunction

  function automatic crcm_pkg::res_t classify(logic [crcm_pkg::CP_W-1:0] cp);
    int lo, hi, mid;
    crcm_pkg::res_t r;
    lo = 0;
    hi = map_size;
    r = '{class_out: miss_class, matched: 1'b0, status: crcm_pkg::ST_DONE};
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (cp > map_tab[mid].last) lo = mid + 1;
      else if (cp < map_tab[mid].first) hi = mid;
      else begin
        r.class_out = map_tab[mid].cls;
        r.matched = 1'b1;
        return r;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    crcm_pkg::res_t r, e;
    if (!rst_ni) begin
      map_size = 0;
      miss_class = '0;
      expected_res.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) miss_class = cfg_data_i;
      if (out_valid_i && !out_stall_i) begin
        if (expected_res.size() == 0) begin
          report_mismatch("unexpected result", class_out_i, -1);
        end else begin
          e = expected_res.pop_front();
          if (class_out_i !== e.class_out)
            report_mismatch("class_out", class_out_i, e.class_out);
          if (matched_i !== e.matched) report_mismatch("matched", matched_i, e.matched);
          if (status_i !== e.status) report_mismatch("status", status_i, e.status);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (mode_i == crcm_pkg::MODE_ADD) begin
          r = '{class_out: '0, matched: 1'b0, status: crcm_pkg::ST_DONE};
          r.status = insert_range(range_first_i, range_last_i, class_id_i);
        end else begin
          r = classify(code_point_i);
        end
        expected_res.push_back(r);
      end
      pending_o = expected_res.size();
    end
  end
endmodule

@@ bench/testbench.sv @@
// Top of the range class map testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS   = 1150;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       mode = crcm_pkg::MODE_LOOKUP;
  logic [crcm_pkg::CP_W-1:0]  range_first = '0;
  logic [crcm_pkg::CP_W-1:0]  range_last = '0;
  logic [crcm_pkg::CLS_W-1:0] class_id = '0;
  logic [crcm_pkg::CP_W-1:0]  code_point = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [crcm_pkg::CLS_W-1:0] class_out;
  logic                       matched;
  logic                       status;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [crcm_pkg::CLS_W-1:0] cfg_data = '0;
  int                         fail_count;
  int                         pending;
  int                         idle_cycles = 0;
  bit                         stall_enable = 1'b1;

  always #4 clk_i = ~clk_i;

  char_range_class_map u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .mode_i(mode), .range_first_i(range_first), .range_last_i(range_last),
    .class_id_i(class_id), .code_point_i(code_point),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .class_out_o(class_out), .matched_o(matched), .status_o(status),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  range_map_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .mode_i(mode), .range_first_i(range_first), .range_last_i(range_last),
    .class_id_i(class_id), .code_point_i(code_point),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .class_out_i(class_out), .matched_i(matched), .status_i(status),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // The receiver stalls in random bursts, changing only on the falling edge.
  always @(negedge clk_i) begin
    if (!stall_enable) out_stall <= 1'b0;
    else if ($urandom_range(0, 99) < 15) out_stall <= ~out_stall;
  end

  // The watchdog counts cycles in which no transfer takes place on any channel.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results pending", pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Present one item and hold it until it is accepted. Valid stays high into the
  // next item when there is no gap; drain() drops it at the end of a sequence.
  task automatic send_item(logic m, logic [crcm_pkg::CP_W-1:0] f,
                           logic [crcm_pkg::CP_W-1:0] l,
                           logic [crcm_pkg::CLS_W-1:0] c,
                           logic [crcm_pkg::CP_W-1:0] cp);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid    <= 1'b1;
    mode        <= m;
    range_first <= f;
    range_last  <= l;
    class_id    <= c;
    code_point  <= cp;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  // Wait for every expected result plus the tail of the block's work.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic write_default(logic [crcm_pkg::CLS_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // A code point that tends to land on the few boundaries in play.
  function automatic logic [crcm_pkg::CP_W-1:0] pick_cp(int span);
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return crcm_pkg::CP_W'($urandom());
    if (roll == 1) return crcm_pkg::CP_W'(21'h1FFFFF - $urandom_range(0, 3));
    return crcm_pkg::CP_W'($urandom_range(0, span));
  endfunction

  task automatic random_phase(int count, int span, int add_pct, int class_span);
    logic [crcm_pkg::CP_W-1:0] f, l;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < add_pct) begin
        f = pick_cp(span);
        // Most adds are short ranges; a few are reversed and stay empty.
        if ($urandom_range(0, 19) == 0) l = f - crcm_pkg::CP_W'($urandom_range(1, 5));
        else l = f + crcm_pkg::CP_W'($urandom_range(0, span / 16));
        send_item(crcm_pkg::MODE_ADD, f, l,
                  crcm_pkg::CLS_W'($urandom_range(0, class_span)),
                  crcm_pkg::CP_W'($urandom()));
      end else begin
        send_item(crcm_pkg::MODE_LOOKUP, crcm_pkg::CP_W'($urandom()),
                  crcm_pkg::CP_W'($urandom()), crcm_pkg::CLS_W'($urandom()),
                  pick_cp(span));
      end
    end
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: lookups into the empty table, then cuts, splits and merges.
    write_default(8'hFF);
    send_item(crcm_pkg::MODE_LOOKUP, '0, '0, '0, 21'd0);
    send_item(crcm_pkg::MODE_LOOKUP, '1, '1, '1, 21'h1FFFFF);
    send_item(crcm_pkg::MODE_ADD, 21'd0, 21'd127, 8'd1, '0);
    send_item(crcm_pkg::MODE_LOOKUP, '0, '0, '0, 21'd65);
    send_item(crcm_pkg::MODE_LOOKUP, '0, '0, '0, 21'd128);
    send_item(crcm_pkg::MODE_ADD, 21'd20, 21'd10, 8'd2, '1);
    send_item(crcm_pkg::MODE_ADD, 21'd5, 21'd50, 8'd1, '0);
    send_item(crcm_pkg::MODE_ADD, 21'd40, 21'd60, 8'd3, '0);
    send_item(crcm_pkg::MODE_LOOKUP, '0, '0, '0, 21'd50);
    send_item(crcm_pkg::MODE_ADD, 21'd128, 21'd200, 8'd1, '0);
    send_item(crcm_pkg::MODE_ADD, 21'd30, 21'd300, 8'd0, '0);
    send_item(crcm_pkg::MODE_ADD, 21'h10FFFF, 21'h1FFFFF, 8'hFF, '0);
    send_item(crcm_pkg::MODE_LOOKUP, '0, '0, '0, 21'h1FFFFE);
    send_item(crcm_pkg::MODE_ADD, 21'd0, 21'h1FFFFF, 8'd7, '0);
    send_item(crcm_pkg::MODE_LOOKUP, '0, '0, '0, 21'd99);
    // Fill the table with isolated ranges until adds are refused as full.
    for (int i = 0; i < 70; i++)
      send_item(crcm_pkg::MODE_ADD, 21'(i * 4), 21'(i * 4 + 1), 8'(i[0]), '0);
    send_item(crcm_pkg::MODE_LOOKUP, '0, '0, '0, 21'd9);

    // Hold off until every result has come back before rewriting the register.
    stall_enable = 1'b0;
    drain();
    write_default(8'h00);
    stall_enable = 1'b1;

    // Random phases over narrow and wide code-point spans with several defaults.
    random_phase(300, 400, 40, 3);
    drain();
    write_default(8'h5A);
    random_phase(300, 5000, 35, 255);
    drain();
    write_default(8'hA5);
    random_phase(300, 300, 60, 1);
    drain();
    write_default(8'hFF);
    random_phase(RANDOM_ITEMS - 900, 2000, 30, 15);
    drain();

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
